// ===== src/lrm_pkg.sv =====
// Shared constants for the lens distortion ray map unit.
package lrm_pkg;

    localparam int IMAGE_COLS = 320;
    localparam int IMAGE_ROWS = 240;
    localparam int FRAC_BITS  = 24;

    localparam int PIX_SCALE  = 100000;
    localparam int COEF_SCALE = 100000000;
    localparam int COEF_N     = 6;

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [2:0] REG_CENTER_X     = 3'd0;
    localparam logic [2:0] REG_CENTER_Y     = 3'd1;
    localparam logic [2:0] REG_FOCAL_X      = 3'd2;
    localparam logic [2:0] REG_FOCAL_Y      = 3'd3;
    localparam logic [2:0] REG_RADIAL_K1    = 3'd4;
    localparam logic [2:0] REG_RADIAL_K2    = 3'd5;
    localparam logic [2:0] REG_RADIAL_HIGH  = 3'd6;
    localparam logic [2:0] REG_TANGENTIAL   = 3'd7;

endpackage

// ===== src/lrm_mulq.sv =====
// Four-stage signed fixed-point multiplier: rounded half away from zero, saturated.
module lrm_mulq #(
    parameter int FRAC_BITS = lrm_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic signed [63:0] o_p
);

    logic [63:0]        r_ma, r_mb;
    logic               r_neg1, r_neg2, r_neg3;
    logic [63:0]        r_hh, r_hl, r_lh, r_ll;
    logic [127:0]       r_sum;
    logic signed [63:0] r_p;
    logic [127:0]       n_sum;
    logic               w_sat;
    logic [63:0]        w_mag;

    always_comb begin
        n_sum = {r_hh, 64'd0} + {32'd0, r_hl, 32'd0} + {32'd0, r_lh, 32'd0}
              + {64'd0, r_ll} + (128'd1 << (FRAC_BITS - 1));
        w_sat = |r_sum[127:63+FRAC_BITS];
        w_mag = w_sat ? lrm_pkg::Q_MAX : r_sum[63+FRAC_BITS:FRAC_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb   <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg1 <= i_a[63] ^ i_b[63];
            r_hh   <= 64'(r_ma[63:32] * r_mb[63:32]);
            r_hl   <= 64'(r_ma[63:32] * r_mb[31:0]);
            r_lh   <= 64'(r_ma[31:0] * r_mb[63:32]);
            r_ll   <= 64'(r_ma[31:0] * r_mb[31:0]);
            r_neg2 <= r_neg1;
            r_sum  <= n_sum;
            r_neg3 <= r_neg2;
            r_p    <= r_neg3 ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_p = r_p;

endmodule

// ===== src/lens_distortion_ray_map_unit.sv =====
// Lens distortion ray map: pixel coordinate to Brown-Conrady distorted ray direction.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_pixel_col, i_pixel_row
//  out      output     o_out_valid / i_out_ready o_ray_x, o_ray_y, o_saturated
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel per cycle while the output is not stalled and no coefficient conversion
// runs; each pixel passes the restoring divider (one quotient bit per stage) and the
// chain of four-stage multipliers for r^8 and the radial product.
// A write to a coefficient register starts a serial conversion of all six
// coefficients, with both input and cfg ready low.
// Synchronous active-low reset clears valid bits and configuration registers. Output stall
// freezes the whole pipeline.
module lens_distortion_ray_map_unit #(
    parameter int IMAGE_COLS = lrm_pkg::IMAGE_COLS,
    parameter int IMAGE_ROWS = lrm_pkg::IMAGE_ROWS,
    parameter int FRAC_BITS  = lrm_pkg::FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [8:0]         i_pixel_col,
    input  logic [7:0]         i_pixel_row,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_ray_x,
    output logic signed [31:0] o_ray_y,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    localparam int NW      = 33 + FRAC_BITS;
    localparam int VL      = NW + 30;
    localparam int CW      = FRAC_BITS + 7;
    localparam int C_SHIFT = NW + 27;
    localparam logic [63:0] C_RECIP = 64'(((128'd1 << C_SHIFT)
        + 128'(lrm_pkg::COEF_SCALE - 1)) / 128'(lrm_pkg::COEF_SCALE));
    localparam logic signed [63:0] ONE  = 64'sd1 << FRAC_BITS;
    localparam logic signed [64:0] S_HI = 65'(lrm_pkg::Q_MAX);
    localparam logic signed [64:0] S_LO = -S_HI;

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_STEP, C_STORE} t_cst;

    function automatic logic signed [63:0] f_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > S_HI)
            return lrm_pkg::Q_MAX;
        else if (s < S_LO)
            return -lrm_pkg::Q_MAX;
        else
            return s[63:0];
    endfunction

    function automatic logic [32:0] f_clip(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < -64'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    // configuration and coefficient conversion
    // quotient by 10^8 through a reciprocal rounded up, one 32x32 partial product per cycle
    t_cst                 r_cst;
    logic signed [31:0]   r_cx, r_cy;
    logic [30:0]          r_fx, r_fy;
    logic signed [31:0]   r_craw [0:lrm_pkg::COEF_N-1];
    logic signed [CW-1:0] r_coef [0:lrm_pkg::COEF_N-1];
    logic [2:0]           r_ci;
    logic [NW-1:0]        r_cw;
    logic [127:0]         r_cacc;
    logic                 r_cneg;
    logic [1:0]           r_ccnt;

    logic signed [31:0]   w_craw;
    logic [31:0]          w_cmag;
    logic [NW-1:0]        w_cnum;
    logic [63:0]          w_cn64;
    logic [31:0]          w_cna, w_cmb;
    logic [63:0]          w_cpp;
    logic [1:0]           w_csum;
    logic [127:0]         w_cadd;
    logic [CW-1:0]        w_cqm;
    logic signed [CW-1:0] w_cq;

    always_comb begin
        w_craw = r_craw[r_ci];
        w_cmag = w_craw[31] ? 32'(-w_craw) : 32'(w_craw);
        w_cnum = (NW'(w_cmag) << FRAC_BITS) + NW'(lrm_pkg::COEF_SCALE / 2);
        w_cn64 = 64'(r_cw);
        w_cna  = r_ccnt[0] ? w_cn64[63:32] : w_cn64[31:0];
        w_cmb  = r_ccnt[1] ? C_RECIP[63:32] : C_RECIP[31:0];
        w_cpp  = 64'(w_cna * w_cmb);
        w_csum = {1'b0, r_ccnt[0]} + {1'b0, r_ccnt[1]};
        w_cadd = 128'(w_cpp) << {w_csum, 5'd0};
        w_cqm  = r_cacc[C_SHIFT +: CW];
        w_cq   = r_cneg ? -$signed(w_cqm) : $signed(w_cqm);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst <= C_IDLE;
            r_cx  <= '0;
            r_cy  <= '0;
            r_fx  <= 31'd1;
            r_fy  <= 31'd1;
            r_ci  <= '0;
            for (int i = 0; i < lrm_pkg::COEF_N; i++) begin
                r_craw[i] <= '0;
                r_coef[i] <= '0;
            end
        end else begin
            case (r_cst)
                C_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            lrm_pkg::REG_CENTER_X: r_cx <= i_cfg_data[31:0];
                            lrm_pkg::REG_CENTER_Y: r_cy <= i_cfg_data[31:0];
                            lrm_pkg::REG_FOCAL_X:
                                r_fx <= (i_cfg_data[30:0] == '0) ? 31'd1 : i_cfg_data[30:0];
                            lrm_pkg::REG_FOCAL_Y:
                                r_fy <= (i_cfg_data[30:0] == '0) ? 31'd1 : i_cfg_data[30:0];
                            lrm_pkg::REG_RADIAL_K1: begin
                                r_craw[0] <= i_cfg_data[31:0];
                                r_ci      <= '0;
                                r_cst     <= C_LOAD;
                            end
                            lrm_pkg::REG_RADIAL_K2: begin
                                r_craw[1] <= i_cfg_data[31:0];
                                r_ci      <= '0;
                                r_cst     <= C_LOAD;
                            end
                            lrm_pkg::REG_RADIAL_HIGH: begin
                                r_craw[2] <= i_cfg_data[31:0];
                                r_craw[3] <= i_cfg_data[63:32];
                                r_ci      <= '0;
                                r_cst     <= C_LOAD;
                            end
                            lrm_pkg::REG_TANGENTIAL: begin
                                r_craw[4] <= i_cfg_data[31:0];
                                r_craw[5] <= i_cfg_data[63:32];
                                r_ci      <= '0;
                                r_cst     <= C_LOAD;
                            end
                            default: ;
                        endcase
                    end
                end
                C_LOAD: begin
                    r_cw   <= w_cnum;
                    r_cacc <= '0;
                    r_cneg <= w_craw[31];
                    r_ccnt <= '0;
                    r_cst  <= C_STEP;
                end
                C_STEP: begin
                    r_cacc <= r_cacc + w_cadd;
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == 2'd3)
                        r_cst <= C_STORE;
                end
                C_STORE: begin
                    r_coef[r_ci] <= w_cq;
                    if (r_ci == 3'(lrm_pkg::COEF_N - 1)) begin
                        r_cst <= C_IDLE;
                    end else begin
                        r_ci  <= r_ci + 1'b1;
                        r_cst <= C_LOAD;
                    end
                end
                default: r_cst <= C_IDLE;
            endcase
        end
    end

    assign o_cfg_ready = (r_cst == C_IDLE);

    // pipeline control
    logic w_en, w_acc;
    logic r_vld [1:VL];
    logic r_ov;

    assign w_en        = !r_ov || i_out_ready;
    assign o_in_ready  = w_en && (r_cst == C_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int t = 1; t <= VL; t++)
                r_vld[t] <= 1'b0;
        end else if (w_en) begin
            r_vld[1] <= w_acc;
            for (int t = 2; t <= VL; t++)
                r_vld[t] <= r_vld[t-1];
            r_ov <= r_vld[VL];
        end
    end

    // normalise: lane 0 is x, lane 1 is y
    logic signed [12:0] w_du, w_dv;
    logic signed [33:0] w_nn   [0:1];
    logic [31:0]        w_nmag [0:1];
    logic [NW-1:0]      w_num  [0:1];
    logic [30:0]        w_den  [0:1];

    assign w_du = $signed({4'b0000, i_pixel_col}) - $signed(13'(IMAGE_COLS - 1));
    assign w_dv = $signed({5'b00000, i_pixel_row}) - $signed(13'(IMAGE_ROWS - 1));

    always_comb begin
        w_den[0] = r_fx;
        w_den[1] = r_fy;
        w_nn[0]  = 34'(w_du) * $signed(34'(lrm_pkg::PIX_SCALE)) + 34'(r_cx);
        w_nn[1]  = 34'(w_dv) * $signed(34'(lrm_pkg::PIX_SCALE)) + 34'(r_cy);
        for (int l = 0; l < 2; l++) begin
            w_nmag[l] = w_nn[l][33] ? 32'(-w_nn[l]) : 32'(w_nn[l]);
            w_num[l]  = (NW'(w_nmag[l]) << FRAC_BITS) + NW'(w_den[l] >> 1);
        end
    end

    // restoring divider, one quotient bit per stage
    logic [NW-1:0] r_dw [0:1][0:NW];
    logic [30:0]   r_dr [0:1][0:NW];
    logic          r_dn [0:1][0:NW];
    logic [31:0]   w_drs [0:1][1:NW];
    logic          w_dge [0:1][1:NW];
    logic signed [63:0] r_xv [0:1];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int k = 1; k <= NW; k++) begin
                w_drs[l][k] = {r_dr[l][k-1], r_dw[l][k-1][NW-1]};
                w_dge[l][k] = w_drs[l][k] >= {1'b0, w_den[l]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 2; l++) begin
                r_dw[l][0] <= w_num[l];
                r_dr[l][0] <= '0;
                r_dn[l][0] <= w_nn[l][33];
                for (int k = 1; k <= NW; k++) begin
                    r_dw[l][k] <= {r_dw[l][k-1][NW-2:0], w_dge[l][k]};
                    r_dr[l][k] <= w_dge[l][k] ? 31'(w_drs[l][k] - {1'b0, w_den[l]})
                                              : w_drs[l][k][30:0];
                    r_dn[l][k] <= r_dn[l][k-1];
                end
                r_xv[l] <= r_dn[l][NW] ? -$signed(64'(r_dw[l][NW]))
                                       : $signed(64'(r_dw[l][NW]));
            end
        end
    end

    // polynomial
    logic signed [63:0] w_xx, w_yy, w_xy, w_r4, w_r6, w_r8;
    logic signed [63:0] w_kr [0:3];
    logic signed [63:0] w_p1xy, w_p2xy, w_p2sx, w_p1sy, w_xrad, w_yrad;
    logic signed [63:0] r_r2, r_dxx, r_dyy, r_sx, r_sy;
    logic signed [63:0] r_r2d [1:8];
    logic signed [63:0] r_radp [0:2];
    logic signed [63:0] r_radd [0:2][1:3];
    logic signed [63:0] r_rad;
    logic signed [63:0] r_xd [0:1][1:22];
    logic signed [63:0] r_t1x, r_t2y;
    logic signed [63:0] r_t1xd [1:17];
    logic signed [63:0] r_p2sxd [1:17];
    logic signed [63:0] r_p1syd [1:16];
    logic signed [63:0] r_t2yd [1:18];
    logic signed [63:0] r_xd1, r_yd1, r_xdf, r_ydf;
    logic signed [31:0] r_ox, r_oy;
    logic               r_osat;
    logic [32:0]        w_cx, w_cy;

    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_xx (.i_clk, .i_en(w_en),
        .i_a(r_xv[0]), .i_b(r_xv[0]), .o_p(w_xx));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_yy (.i_clk, .i_en(w_en),
        .i_a(r_xv[1]), .i_b(r_xv[1]), .o_p(w_yy));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_xy (.i_clk, .i_en(w_en),
        .i_a(r_xv[0]), .i_b(r_xv[1]), .o_p(w_xy));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_r4 (.i_clk, .i_en(w_en),
        .i_a(r_r2), .i_b(r_r2), .o_p(w_r4));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_r6 (.i_clk, .i_en(w_en),
        .i_a(w_r4), .i_b(r_r2d[4]), .o_p(w_r6));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_r8 (.i_clk, .i_en(w_en),
        .i_a(w_r6), .i_b(r_r2d[8]), .o_p(w_r8));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_k1 (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[0])), .i_b(r_r2), .o_p(w_kr[0]));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_k2 (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[1])), .i_b(w_r4), .o_p(w_kr[1]));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_k3 (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[2])), .i_b(w_r6), .o_p(w_kr[2]));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_k4 (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[3])), .i_b(w_r8), .o_p(w_kr[3]));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_p1xy (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[4])), .i_b(w_xy), .o_p(w_p1xy));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_p2xy (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[5])), .i_b(w_xy), .o_p(w_p2xy));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_p2sx (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[5])), .i_b(r_sx), .o_p(w_p2sx));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_p1sy (.i_clk, .i_en(w_en),
        .i_a(64'(r_coef[4])), .i_b(r_sy), .o_p(w_p1sy));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_xrad (.i_clk, .i_en(w_en),
        .i_a(r_xd[0][22]), .i_b(r_rad), .o_p(w_xrad));
    lrm_mulq #(.FRAC_BITS(FRAC_BITS)) u_yrad (.i_clk, .i_en(w_en),
        .i_a(r_xd[1][22]), .i_b(r_rad), .o_p(w_yrad));

    assign w_cx = f_clip(r_xdf);
    assign w_cy = f_clip(r_ydf);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2  <= f_sat(w_xx, w_yy);
            r_dxx <= f_sat(w_xx, w_xx);
            r_dyy <= f_sat(w_yy, w_yy);
            r_sx  <= f_sat(r_r2, r_dxx);
            r_sy  <= f_sat(r_r2, r_dyy);
            r_r2d[1] <= r_r2;
            for (int i = 2; i <= 8; i++)
                r_r2d[i] <= r_r2d[i-1];

            // radial terms are summed in order, one saturating add per stage
            r_radp[0] <= f_sat(ONE, w_kr[0]);
            r_radp[1] <= f_sat(r_radd[0][3], w_kr[1]);
            r_radp[2] <= f_sat(r_radd[1][3], w_kr[2]);
            for (int j = 0; j < 3; j++) begin
                r_radd[j][1] <= r_radp[j];
                for (int i = 2; i <= 3; i++)
                    r_radd[j][i] <= r_radd[j][i-1];
            end
            r_rad <= f_sat(r_radd[2][3], w_kr[3]);

            for (int l = 0; l < 2; l++) begin
                r_xd[l][1] <= r_xv[l];
                for (int i = 2; i <= 22; i++)
                    r_xd[l][i] <= r_xd[l][i-1];
            end

            r_t1x <= f_sat(w_p1xy, w_p1xy);
            r_t2y <= f_sat(w_p2xy, w_p2xy);
            r_t1xd[1]  <= r_t1x;
            r_p2sxd[1] <= w_p2sx;
            r_p1syd[1] <= w_p1sy;
            r_t2yd[1]  <= r_t2y;
            for (int i = 2; i <= 17; i++) begin
                r_t1xd[i]  <= r_t1xd[i-1];
                r_p2sxd[i] <= r_p2sxd[i-1];
            end
            for (int i = 2; i <= 16; i++)
                r_p1syd[i] <= r_p1syd[i-1];
            for (int i = 2; i <= 18; i++)
                r_t2yd[i] <= r_t2yd[i-1];

            r_xd1 <= f_sat(w_xrad, r_t1xd[17]);
            r_yd1 <= f_sat(w_yrad, r_p1syd[16]);
            r_xdf <= f_sat(r_xd1, r_p2sxd[17]);
            r_ydf <= f_sat(r_yd1, r_t2yd[18]);

            r_ox   <= w_cx[31:0];
            r_oy   <= w_cy[31:0];
            r_osat <= w_cx[32] | w_cy[32];
        end
    end

    assign o_ray_x     = r_ox;
    assign o_ray_y     = r_oy;
    assign o_saturated = r_osat;

endmodule

// ===== tb/lrm_checker.sv =====
// Checker for the lens distortion ray map unit: predicts each ray and compares it at the output.
module lrm_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [8:0]         i_pixel_col,
    input  logic [7:0]         i_pixel_row,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_ray_x,
    input  logic signed [31:0] i_ray_y,
    input  logic               i_saturated,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_ray_count,
    output int                 o_clip_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] ray_x;
        logic signed [31:0] ray_y;
        logic               saturated;
    } t_ray;

    localparam logic signed [63:0] Q_ONE = 64'sd1 <<< lrm_pkg::FRAC_BITS;

    t_ray        rays_due[$];
    logic [31:0] centre_x, centre_y, k1_raw, k2_raw;
    logic [30:0] focal_x, focal_y;
    logic [63:0] k34_raw, p12_raw;

    function automatic logic signed [63:0] clamp_q(input logic signed [64:0] v);
        if (v > 65'sd0 + lrm_pkg::Q_MAX) return lrm_pkg::Q_MAX;
        if (v < -(65'sd0 + lrm_pkg::Q_MAX)) return -lrm_pkg::Q_MAX;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] add_q(input logic signed [63:0] a, b);
        return clamp_q(65'(a) + 65'(b));
    endfunction

    // round(num * 2^F / den), half away from zero
    function automatic logic signed [63:0] div_q(input logic signed [63:0] num,
                                                 input logic [63:0] den);
        logic [63:0] mag, q;
        mag = num < 0 ? -num : num;
        q = ((mag << lrm_pkg::FRAC_BITS) + den / 2) / den;
        if (q > lrm_pkg::Q_MAX) q = lrm_pkg::Q_MAX;
        return num < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [63:0] mul_q(input logic signed [63:0] a, b);
        logic [63:0]  ma, mb, r;
        logic [127:0] p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = {64'd0, ma} * {64'd0, mb} + (128'd1 << (lrm_pkg::FRAC_BITS - 1));
        if ((p >> (63 + lrm_pkg::FRAC_BITS)) != 0) r = lrm_pkg::Q_MAX;
        else r = p[lrm_pkg::FRAC_BITS +: 64];
        return ((a < 0) != (b < 0)) ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v,
                                                  inout logic clipped);
        if (v > 64'sh7FFF_FFFF) begin
            clipped = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sh8000_0000) begin
            clipped = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_ray predict_ray(input logic [8:0] col, input logic [7:0] row);
        logic signed [63:0] nx, ny, x, y, k1, k2, k3, k4, p1, p2;
        logic signed [63:0] xx, yy, xy, r2, r4, r6, r8, radial, xd, yd;
        logic [63:0]        fx, fy;
        logic               clipped;
        t_ray               res;
        fx = focal_x == 0 ? 64'd1 : 64'(focal_x);
        fy = focal_y == 0 ? 64'd1 : 64'(focal_y);
        nx = (64'(col) - (lrm_pkg::IMAGE_COLS - 1)) * lrm_pkg::PIX_SCALE
             + 64'($signed(centre_x));
        ny = (64'(row) - (lrm_pkg::IMAGE_ROWS - 1)) * lrm_pkg::PIX_SCALE
             + 64'($signed(centre_y));
        x = div_q(nx, fx);
        y = div_q(ny, fy);
        k1 = div_q(64'($signed(k1_raw)), lrm_pkg::COEF_SCALE);
        k2 = div_q(64'($signed(k2_raw)), lrm_pkg::COEF_SCALE);
        k3 = div_q(64'($signed(k34_raw[31:0])), lrm_pkg::COEF_SCALE);
        k4 = div_q(64'($signed(k34_raw[63:32])), lrm_pkg::COEF_SCALE);
        p1 = div_q(64'($signed(p12_raw[31:0])), lrm_pkg::COEF_SCALE);
        p2 = div_q(64'($signed(p12_raw[63:32])), lrm_pkg::COEF_SCALE);
        xx = mul_q(x, x);
        yy = mul_q(y, y);
        xy = mul_q(x, y);
        r2 = add_q(xx, yy);
        r4 = mul_q(r2, r2);
        r6 = mul_q(r4, r2);
        r8 = mul_q(r6, r2);
        radial = add_q(Q_ONE, mul_q(k1, r2));
        radial = add_q(radial, mul_q(k2, r4));
        radial = add_q(radial, mul_q(k3, r6));
        radial = add_q(radial, mul_q(k4, r8));
        xd = mul_q(x, radial);
        xd = add_q(xd, add_q(mul_q(p1, xy), mul_q(p1, xy)));
        xd = add_q(xd, mul_q(p2, add_q(r2, add_q(xx, xx))));
        yd = mul_q(y, radial);
        yd = add_q(yd, mul_q(p1, add_q(r2, add_q(yy, yy))));
        yd = add_q(yd, add_q(mul_q(p2, xy), mul_q(p2, xy)));
        clipped = 1'b0;
        res.ray_x = clip32(xd, clipped);
        res.ray_y = clip32(yd, clipped);
        res.saturated = clipped;
        return res;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        o_fail_count++;
        $display("%0t ERROR ray %0d: %s got %h want %h", $realtime, o_ray_count, what,
                 got, want);
    endtask

    assign o_pending = rays_due.size();

    always @(posedge i_clk) begin
        t_ray want;
        if (!i_rst_n) begin
            centre_x <= '0;
            centre_y <= '0;
            focal_x  <= 31'd1;
            focal_y  <= 31'd1;
            k1_raw   <= '0;
            k2_raw   <= '0;
            k34_raw  <= '0;
            p12_raw  <= '0;
            rays_due.delete();
            o_fail_count = 0;
            o_ray_count  = 0;
            o_clip_count = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                rays_due.push_back(predict_ray(i_pixel_col, i_pixel_row));
            if (i_out_valid && i_out_ready) begin
                if (rays_due.size() == 0) begin
                    report("unexpected transaction", i_ray_x, 32'd0);
                end else begin
                    want = rays_due.pop_front();
                    if (i_ray_x !== want.ray_x) report("ray_x", i_ray_x, want.ray_x);
                    if (i_ray_y !== want.ray_y) report("ray_y", i_ray_y, want.ray_y);
                    if (i_saturated !== want.saturated)
                        report("saturated", 32'(i_saturated), 32'(want.saturated));
                    if (want.saturated) o_clip_count++;
                end
                o_ray_count++;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lrm_pkg::REG_CENTER_X:    centre_x <= i_cfg_data[31:0];
                    lrm_pkg::REG_CENTER_Y:    centre_y <= i_cfg_data[31:0];
                    lrm_pkg::REG_FOCAL_X:     focal_x  <= i_cfg_data[30:0];
                    lrm_pkg::REG_FOCAL_Y:     focal_y  <= i_cfg_data[30:0];
                    lrm_pkg::REG_RADIAL_K1:   k1_raw   <= i_cfg_data[31:0];
                    lrm_pkg::REG_RADIAL_K2:   k2_raw   <= i_cfg_data[31:0];
                    lrm_pkg::REG_RADIAL_HIGH: k34_raw  <= i_cfg_data;
                    lrm_pkg::REG_TANGENTIAL:  p12_raw  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/tb.sv =====
// Testbench top for the lens distortion ray map unit: stimulus, register setup and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = lrm_pkg::FRAC_BITS + 80;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [8:0]         i_pixel_col = '0;
    logic [7:0]         i_pixel_row = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_ray_x, o_ray_y;
    logic               o_saturated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [63:0]        i_cfg_data = '0;

    int fail_count, pending, ray_count, clip_count;
    int cycles = 0;
    int settings_used = 0;
    bit no_idle = 1'b0;
    int hold_reqs = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    lens_distortion_ray_map_unit dut (.*);

    lrm_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready), .i_pixel_col, .i_pixel_row,
        .i_out_valid(o_out_valid), .i_out_ready, .i_ray_x(o_ray_x), .i_ray_y(o_ray_y),
        .i_saturated(o_saturated),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending), .o_ray_count(ray_count),
        .o_clip_count(clip_count)
    );

    function automatic int pick_gap();
        int n;
        n = $urandom_range(0, 99);
        if (no_idle || n < 60) return 0;
        if (n < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    initial begin
        int g;
        int holds_done;
        holds_done = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_reqs != holds_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holds_done++;
            end else if (no_idle) begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    task automatic send_pixel(input logic [8:0] col, input logic [7:0] row);
        int g;
        i_in_valid  <= 1'b1;
        i_pixel_col <= col;
        i_pixel_row <= row;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_lens(input logic [31:0] cx, cy, input logic [30:0] fx, fy,
                             input logic [31:0] k1, k2, input logic [63:0] k34, p12);
        write_reg(lrm_pkg::REG_CENTER_X, {32'd0, cx});
        write_reg(lrm_pkg::REG_CENTER_Y, {32'd0, cy});
        write_reg(lrm_pkg::REG_FOCAL_X, {33'd0, fx});
        write_reg(lrm_pkg::REG_FOCAL_Y, {33'd0, fy});
        write_reg(lrm_pkg::REG_RADIAL_K1, {32'd0, k1});
        write_reg(lrm_pkg::REG_RADIAL_K2, {32'd0, k2});
        write_reg(lrm_pkg::REG_RADIAL_HIGH, k34);
        write_reg(lrm_pkg::REG_TANGENTIAL, p12);
        settings_used++;
    endtask

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return 32'($signed($urandom_range(0, 60_000_000)) - 30_000_000);
    endfunction

    task automatic directed_corners();
        send_pixel(9'd0, 8'd0);
        send_pixel(9'd319, 8'd239);
        send_pixel(9'd511, 8'd255);
        send_pixel(9'd0, 8'd255);
        send_pixel(9'd511, 8'd0);
        send_pixel(9'd160, 8'd120);
        send_pixel(9'd320, 8'd240);
    endtask

    initial begin
        logic [31:0] cx, cy;
        logic [30:0] fx, fy;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: unit focal length drives every pixel but the centre one into clipping
        directed_corners();
        drain();

        // a plausible lens with barrel distortion
        no_idle = 1'b1;
        load_lens(32'd15_950_000, 32'd11_950_000, 31'd25_000_000, 31'd25_000_000,
                  -32'sd30_000_000, 32'sd10_000_000, {-32'sd1_000_000, 32'sd2_000_000},
                  {32'sd50_000, -32'sd80_000});
        directed_corners();
        send_pixel(9'd1, 8'd1);
        drain();
        no_idle = 1'b0;

        // extremes: centre limits, widest and zero focal, coefficient limits
        load_lens(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0,
                  32'h7FFF_FFFF, 32'h8000_0000, {32'h8000_0000, 32'h7FFF_FFFF},
                  {32'h7FFF_FFFF, 32'h8000_0000});
        directed_corners();
        drain();
        load_lens(32'h7FFF_FFFF, 32'h8000_0000, 31'd0, 31'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF, {32'h7FFF_FFFF, 32'h8000_0000},
                  {32'h8000_0000, 32'h7FFF_FFFF});
        directed_corners();
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            if ($urandom_range(0, 3) == 0) begin
                cx = $urandom();
                cy = $urandom();
                fx = 31'($urandom());
                fy = 31'($urandom());
            end else begin
                cx = $urandom_range(0, 32_000_000);
                cy = $urandom_range(0, 24_000_000);
                fx = $urandom_range(5_000_000, 80_000_000);
                fy = $urandom_range(5_000_000, 80_000_000);
            end
            load_lens(cx, cy, fx, fy, rand_coef(), rand_coef(), {rand_coef(), rand_coef()},
                      {rand_coef(), rand_coef()});
            no_idle = (ph == 3);
            for (int n = 0; n < 256; n++) begin
                if (ph == 1 && n == 40) hold_reqs++;
                if ($urandom_range(0, 4) == 0)
                    send_pixel(9'($urandom()), 8'($urandom()));
                else
                    send_pixel(9'($urandom_range(0, lrm_pkg::IMAGE_COLS - 1)),
                               8'($urandom_range(0, lrm_pkg::IMAGE_ROWS - 1)));
            end
            drain();
        end

        $display("covered %0d rays over %0d lens settings, %0d of them clipped",
                 ray_count, settings_used, clip_count);
        $display("errors seen: %0d, cycles run: %0d", fail_count, cycles);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
